// ===== src/sfmc_pkg.sv =====
// Package for the serial flash card: payload structs, modes, command codes, status bits, cfg, states.
// No dependencies.
package sfmc_pkg;
    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data_in;
    } t_in_item;

    typedef struct packed {
        logic [7:0] data_out;
        logic [7:0] status_out;
        logic       interrupt_out;
    } t_out_item;

    localparam logic [1:0] MODE_XCHG = 2'd0;
    localparam logic [1:0] MODE_SEL  = 2'd1;
    localparam logic [1:0] MODE_REL  = 2'd2;
    localparam logic [1:0] MODE_TICK = 2'd3;

    localparam logic [7:0] CMD_IDENTIFY     = 8'h00;
    localparam logic [7:0] CMD_READ_ARRAY   = 8'h52;
    localparam logic [7:0] CMD_SET_IRQ      = 8'h81;
    localparam logic [7:0] CMD_READ_STATUS  = 8'h83;
    localparam logic [7:0] CMD_READ_ID      = 8'h85;
    localparam logic [7:0] CMD_CLEAR_STATUS = 8'h89;
    localparam logic [7:0] CMD_SECTOR_ERASE = 8'hF1;
    localparam logic [7:0] CMD_PAGE_PROGRAM = 8'hF2;
    localparam logic [7:0] CMD_CHIP_ERASE   = 8'hF4;

    localparam logic [7:0] ST_BUSY      = 8'h80;
    localparam logic [7:0] ST_UNLOCKED  = 8'h40;
    localparam logic [7:0] ST_ERASE_ERR = 8'h10;
    localparam logic [7:0] ST_PROG_ERR  = 8'h08;
    localparam logic [7:0] ST_READY     = 8'h01;

    localparam logic [0:0] CFG_DEVICE_ID  = 1'd0;
    localparam logic [0:0] CFG_DONE_DELAY = 1'd1;

    localparam int BYTES_PER_MBIT = 1024 * 8 * 16;
    localparam int ADDR_W = 25;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_SWEEP,
        S_PROG,
        S_OUT
    } t_state;
endpackage

// ===== src/sfmc_store.sv =====
// Card byte store: one synchronous memory with one write and one read port.
// Depends on nothing but its parameters.
module sfmc_store #(
    parameter int AW = 19
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);
    logic [7:0] r_mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== src/serial_flash_memory_card.sv =====
// Top level of the serial flash card: command decode, sequencer and card store.
// Depends on sfmc_pkg and sfmc_store.
//
//  channel | direction | payload        | handshake
//  in      | to card   | mode, data_in  | i_in_valid / o_in_stall
//  out     | from card | data, status,irq | o_out_valid / i_out_stall
//  cfg     | to card   | index, data    | i_cfg_we
//
// The result of an item is registered in state S_OUT once the item is taken; a
// read-array byte passes through S_READ first for the store read. The next item is
// taken only after the result leaves the output register. A release walks the store
// one byte a cycle: the 8192-byte sector for a sector erase, all CARD_MBIT*131072
// bytes for a chip erase and each buffered byte for a page program.
// After reset, a clearing pass writes 0xFF to every card byte before the first item
// is taken. A full output register stalls input.
module serial_flash_memory_card #(
    parameter int CARD_MBIT = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  sfmc_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output sfmc_pkg::t_out_item  o_out_item,
    input  logic                 i_cfg_we,
    input  logic [0:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data
);
    localparam int CARD_BYTES = CARD_MBIT * sfmc_pkg::BYTES_PER_MBIT;
    localparam int AW = $clog2(CARD_BYTES);

    sfmc_pkg::t_state r_state, n_state;

    logic [15:0] r_device_id, r_done_delay;
    logic [7:0]  r_buf [128];
    logic [7:0]  r_buf_rdata;
    logic [7:0]  r_cmd;
    logic [15:0] r_pos;
    logic [sfmc_pkg::ADDR_W-1:0] r_addr;
    logic [7:0]  r_status;
    logic        r_irq_en, r_irq_pend;
    logic [15:0] r_count;
    logic [AW-1:0] r_walk;      // clear / sweep address
    logic [AW-1:0] r_walk_end;
    logic [15:0]   r_prog_left;
    logic [6:0]    r_buf_idx;
    logic [7:0]    r_data;
    logic          r_out_valid;
    logic          r_prev_read;
    sfmc_pkg::t_out_item r_out;
    sfmc_pkg::t_in_item  r_item;

    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_wdata, mem_rdata;

    logic          buf_we;
    logic [6:0]    buf_waddr, buf_raddr;

    sfmc_store #(.AW(AW)) u_store (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    function automatic logic [sfmc_pkg::ADDR_W-1:0] page_adv(
        input logic [sfmc_pkg::ADDR_W-1:0] a);
        page_adv = {a[sfmc_pkg::ADDR_W-1:9], a[8:0] + 9'd1};
    endfunction

    function automatic logic [sfmc_pkg::ADDR_W-1:0] addr_byte(
        input logic [sfmc_pkg::ADDR_W-1:0] a, input logic [15:0] p,
        input logic [7:0] b);
        logic [sfmc_pkg::ADDR_W-1:0] r;
        r = a;
        case (p)
            16'd1:   r = {b, 17'd0};
            16'd2:   r = a | {8'd0, b, 9'd0};
            16'd3:   r = a | {16'd0, b[1:0], 7'd0};
            16'd4:   r = a | {18'd0, b[6:0]};
            default: r = a;
        endcase
        addr_byte = r;
    endfunction

    logic accept;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != sfmc_pkg::S_IDLE) || r_out_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    logic sec_go, chip_go, prog_go;
    assign sec_go  = (r_cmd == sfmc_pkg::CMD_SECTOR_ERASE) && (r_pos > 16'd2);
    assign chip_go = (r_cmd == sfmc_pkg::CMD_CHIP_ERASE) && (r_pos > 16'd2);
    assign prog_go = (r_cmd == sfmc_pkg::CMD_PAGE_PROGRAM) && (r_pos >= 16'd5);

    // The program buffer is read one entry ahead of the program walk, so the entry
    // for the first write is already fetched when the walk starts.
    assign buf_we    = accept && (i_in_item.mode == sfmc_pkg::MODE_XCHG)
                       && (r_cmd == sfmc_pkg::CMD_PAGE_PROGRAM) && (r_pos >= 16'd5);
    assign buf_waddr = 7'(r_pos - 16'd5);
    assign buf_raddr = (r_state == sfmc_pkg::S_PROG) ? r_buf_idx + 7'd1 : 7'd0;

    always_ff @(posedge i_clk) begin
        if (buf_we) begin
            r_buf[buf_waddr] <= i_in_item.data_in;
        end
        r_buf_rdata <= r_buf[buf_raddr];
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            sfmc_pkg::S_CLEAR: if (r_walk == AW'(CARD_BYTES - 1)) n_state = sfmc_pkg::S_IDLE;
            sfmc_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = sfmc_pkg::S_OUT;
                    if (i_in_item.mode == sfmc_pkg::MODE_XCHG && r_pos > 16'd1
                        && r_cmd == sfmc_pkg::CMD_READ_ARRAY) begin
                        n_state = sfmc_pkg::S_READ;
                    end else if (i_in_item.mode == sfmc_pkg::MODE_REL) begin
                        if (sec_go || chip_go) n_state = sfmc_pkg::S_SWEEP;
                        else if (prog_go && r_pos != 16'd5) n_state = sfmc_pkg::S_PROG;
                    end
                end
            end
            sfmc_pkg::S_READ:  n_state = sfmc_pkg::S_OUT;
            sfmc_pkg::S_SWEEP: if (r_walk == r_walk_end) n_state = sfmc_pkg::S_OUT;
            sfmc_pkg::S_PROG:  if (r_prog_left == 16'd1) n_state = sfmc_pkg::S_OUT;
            sfmc_pkg::S_OUT:   n_state = sfmc_pkg::S_IDLE;
            default:           n_state = sfmc_pkg::S_IDLE;
        endcase
    end

    // Memory port drive.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_walk;
        mem_wdata = 8'hFF;
        mem_raddr = r_addr[AW-1:0];
        case (r_state)
            sfmc_pkg::S_CLEAR, sfmc_pkg::S_SWEEP: mem_we = 1'b1;
            sfmc_pkg::S_PROG: begin
                mem_we    = 1'b1;
                mem_waddr = r_addr[AW-1:0];
                mem_wdata = r_buf_rdata;
            end
            default: mem_we = 1'b0;
        endcase
    end

    logic [sfmc_pkg::ADDR_W-1:0] x_addr;
    assign x_addr = addr_byte(r_addr, r_pos, i_in_item.data_in);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= sfmc_pkg::S_CLEAR;
            r_device_id  <= 16'hC221;
            r_done_delay <= 16'd5000;
            r_cmd        <= sfmc_pkg::CMD_IDENTIFY;
            r_pos        <= '0;
            r_addr       <= '0;
            r_status     <= sfmc_pkg::ST_BUSY | sfmc_pkg::ST_UNLOCKED | sfmc_pkg::ST_READY;
            r_irq_en     <= 1'b0;
            r_irq_pend   <= 1'b0;
            r_count      <= '0;
            r_walk       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_index == sfmc_pkg::CFG_DEVICE_ID) r_device_id <= i_cfg_data;
                else r_done_delay <= i_cfg_data;
            end
            if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
            case (r_state)
                sfmc_pkg::S_CLEAR: r_walk <= r_walk + 1'b1;
                sfmc_pkg::S_IDLE: if (accept) begin
                    r_item <= i_in_item;
                    r_data <= 8'hFF;
                    case (i_in_item.mode)
                        sfmc_pkg::MODE_XCHG: begin
                            if (r_pos == 16'd0) begin
                                r_cmd <= i_in_item.data_in;
                                if (i_in_item.data_in == sfmc_pkg::CMD_CLEAR_STATUS) begin
                                    r_status <= (r_status & ~(sfmc_pkg::ST_PROG_ERR
                                        | sfmc_pkg::ST_ERASE_ERR)) | sfmc_pkg::ST_READY;
                                    r_irq_pend <= 1'b0;
                                end
                            end else begin
                                case (r_cmd)
                                    sfmc_pkg::CMD_IDENTIFY:
                                        if (r_pos == 16'd1) r_data <= 8'h80;
                                        else if (r_pos[1:0] == 2'd1)
                                            r_data <= 8'(CARD_MBIT);
                                        else r_data <= 8'h00;
                                    sfmc_pkg::CMD_READ_ARRAY: r_addr <= x_addr;
                                    sfmc_pkg::CMD_READ_STATUS: r_data <= r_status;
                                    sfmc_pkg::CMD_READ_ID:
                                        if (r_pos == 16'd1 || !r_pos[0])
                                            r_data <= r_device_id[15:8];
                                        else r_data <= r_device_id[7:0];
                                    sfmc_pkg::CMD_SECTOR_ERASE:
                                        if (r_pos <= 16'd2) r_addr <= x_addr;
                                    sfmc_pkg::CMD_SET_IRQ:
                                        if (r_pos == 16'd1)
                                            r_irq_en <= (i_in_item.data_in != 8'd0);
                                    sfmc_pkg::CMD_PAGE_PROGRAM: r_addr <= x_addr;
                                    default: r_data <= 8'hFF;
                                endcase
                            end
                            if (r_pos != 16'hFFFF) r_pos <= r_pos + 16'd1;
                        end
                        sfmc_pkg::MODE_SEL: r_pos <= '0;
                        sfmc_pkg::MODE_REL: begin
                            if (sec_go) begin
                                r_walk     <= {r_addr[AW-1:13], 13'd0};
                                r_walk_end <= {r_addr[AW-1:13], 13'h1FFF};
                                r_status   <= (r_status | sfmc_pkg::ST_BUSY)
                                              & ~sfmc_pkg::ST_READY;
                                r_count    <= (r_done_delay == 16'd0) ? 16'd1 : r_done_delay;
                            end else if (chip_go) begin
                                r_walk     <= '0;
                                r_walk_end <= AW'(CARD_BYTES - 1);
                                r_status   <= r_status & ~sfmc_pkg::ST_BUSY;
                            end else if (prog_go) begin
                                r_status    <= r_status & ~sfmc_pkg::ST_BUSY;
                                r_prog_left <= r_pos - 16'd5;
                                r_buf_idx   <= '0;
                                r_count     <= (r_done_delay == 16'd0) ? 16'd1 : r_done_delay;
                            end
                        end
                        default: begin
                            if (r_count != 16'd0) begin
                                r_count <= r_count - 16'd1;
                                if (r_count == 16'd1) begin
                                    r_status <= (r_status | sfmc_pkg::ST_READY)
                                                & ~sfmc_pkg::ST_BUSY;
                                    r_irq_pend <= 1'b1;
                                end
                            end
                        end
                    endcase
                end
                sfmc_pkg::S_READ: begin
                    if (r_pos > 16'd9) r_addr <= page_adv(r_addr);
                end
                sfmc_pkg::S_SWEEP: r_walk <= r_walk + 1'b1;
                sfmc_pkg::S_PROG: begin
                    r_prog_left <= r_prog_left - 16'd1;
                    r_buf_idx   <= r_buf_idx + 7'd1;
                    r_addr      <= page_adv(r_addr);
                end
                sfmc_pkg::S_OUT: begin
                    r_out_valid <= 1'b1;
                    r_out.data_out <= (r_item.mode == sfmc_pkg::MODE_XCHG
                        && r_cmd == sfmc_pkg::CMD_READ_ARRAY && r_pos > 16'd2
                        && r_prev_read) ? mem_rdata : r_data;
                    r_out.status_out    <= r_status;
                    r_out.interrupt_out <= r_irq_en & r_irq_pend;
                end
                default: r_walk <= r_walk;
            endcase
        end
    end

    // Marks that the item just handled was a card read, so its data is the memory output.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_prev_read <= 1'b0;
        else if (r_state == sfmc_pkg::S_READ) r_prev_read <= 1'b1;
        else if (r_state == sfmc_pkg::S_OUT) r_prev_read <= 1'b0;
    end
endmodule

// ===== src/sfmc_checker.sv =====
// Port checker for the serial flash card, bound to the top level.
// Depends on sfmc_pkg.
module sfmc_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input sfmc_pkg::t_out_item o_out_item
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken with result pending");
    a_no_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> !o_out_valid)
        else $error("result appeared too early");
    a_irq_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result out of reset");
endmodule

bind serial_flash_memory_card sfmc_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
    .o_in_stall(o_in_stall), .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall), .o_out_item(o_out_item)
);

// ===== tb/tb_top.sv =====
// Testbench for serial_flash_memory_card: directed command sequences, then random
// transactions under several idling phases, all checked against a local card model.
// Depends on sfmc_pkg and the RTL of the card.
module tb_top;
    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    sfmc_pkg::t_in_item  in_item;
    logic                out_valid;
    logic                out_stall;
    sfmc_pkg::t_out_item out_item;
    logic                cfg_we;
    logic [0:0]          cfg_index;
    logic [15:0]         cfg_data;

    serial_flash_memory_card dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    localparam int CARD_BYTES = 4 * sfmc_pkg::BYTES_PER_MBIT;

    // Card model state. Bytes missing from flash_mem read as erased.
    logic [7:0]  flash_mem [int];
    logic [7:0]  page_buf [128];
    logic [7:0]  cur_cmd;
    logic [15:0] byte_pos;
    logic [24:0] card_addr;
    logic [7:0]  status_reg;
    logic        irq_en;
    logic        irq_pend;
    logic [15:0] countdown;
    logic [15:0] id_reg;
    logic [15:0] delay_reg;

    sfmc_pkg::t_out_item expected_q[$];
    int          send_idle_pct;
    int          recv_stall_pct;
    int          err_count;
    int          item_count;
    int          result_count;

    initial begin
        clk = 1'b0;
    end
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [7:0] mem_read(logic [24:0] a);
        int k;
        k = int'(a) & (CARD_BYTES - 1);
        return flash_mem.exists(k) ? flash_mem[k] : 8'hFF;
    endfunction

    function automatic logic [24:0] page_next(logic [24:0] a);
        return {a[24:9], a[8:0] + 9'd1};
    endfunction

    function automatic void load_addr_byte(int p, logic [7:0] b);
        if (p == 1)
            card_addr = 25'(b) << 17;
        else if (p == 2)
            card_addr |= 25'(b) << 9;
        else if (p == 3)
            card_addr |= 25'(b[1:0]) << 7;
        else if (p == 4)
            card_addr |= 25'(b[6:0]);
    endfunction

    function automatic logic [7:0] card_exchange(logic [7:0] b);
        int p;
        logic [7:0] r;
        p = int'(byte_pos);
        r = 8'hFF;
        if (p == 0) begin
            cur_cmd = b;
            if (b == sfmc_pkg::CMD_CLEAR_STATUS) begin
                status_reg = (status_reg & ~(sfmc_pkg::ST_PROG_ERR | sfmc_pkg::ST_ERASE_ERR))
                             | sfmc_pkg::ST_READY;
                irq_pend = 1'b0;
            end
        end else begin
            case (cur_cmd)
                sfmc_pkg::CMD_IDENTIFY: begin
                    if (p == 1)
                        r = 8'h80;
                    else
                        r = (((p - 2) & 3) == 3) ? 8'd4 : 8'd0;
                end
                sfmc_pkg::CMD_READ_ARRAY: begin
                    load_addr_byte(p, b);
                    if (p > 1) begin
                        r = mem_read(card_addr);
                        if (p >= 9)
                            card_addr = page_next(card_addr);
                    end
                end
                sfmc_pkg::CMD_READ_STATUS: r = status_reg;
                sfmc_pkg::CMD_READ_ID: begin
                    if (p == 1 || (p & 1) == 0)
                        r = id_reg[15:8];
                    else
                        r = id_reg[7:0];
                end
                sfmc_pkg::CMD_SECTOR_ERASE: begin
                    if (p <= 2)
                        load_addr_byte(p, b);
                end
                sfmc_pkg::CMD_SET_IRQ: begin
                    if (p == 1)
                        irq_en = (b != 8'd0);
                end
                sfmc_pkg::CMD_PAGE_PROGRAM: begin
                    load_addr_byte(p, b);
                    if (p >= 5)
                        page_buf[(p - 5) & 127] = b;
                end
                default: ;
            endcase
        end
        if (byte_pos != 16'hFFFF)
            byte_pos++;
        return r;
    endfunction

    function automatic void card_release();
        int base;
        int n;
        int i;
        if (cur_cmd == sfmc_pkg::CMD_SECTOR_ERASE && byte_pos > 16'd2) begin
            base = (int'(card_addr) & (CARD_BYTES - 1)) & ~8191;
            for (int k = base; k < base + 8192; k++)
                if (flash_mem.exists(k))
                    flash_mem.delete(k);
            status_reg = (status_reg | sfmc_pkg::ST_BUSY) & ~sfmc_pkg::ST_READY;
            countdown = (delay_reg == 16'd0) ? 16'd1 : delay_reg;
        end else if (cur_cmd == sfmc_pkg::CMD_CHIP_ERASE && byte_pos > 16'd2) begin
            flash_mem.delete();
            status_reg = status_reg & ~sfmc_pkg::ST_BUSY;
        end else if (cur_cmd == sfmc_pkg::CMD_PAGE_PROGRAM && byte_pos >= 16'd5) begin
            n = int'(byte_pos) - 5;
            i = 0;
            status_reg = status_reg & ~sfmc_pkg::ST_BUSY;
            while (n > 0) begin
                flash_mem[int'(card_addr) & (CARD_BYTES - 1)] = page_buf[i];
                i = (i + 1) & 127;
                card_addr = page_next(card_addr);
                n--;
            end
            countdown = (delay_reg == 16'd0) ? 16'd1 : delay_reg;
        end
    endfunction

    function automatic sfmc_pkg::t_out_item predict_card(logic [1:0] m, logic [7:0] b);
        sfmc_pkg::t_out_item r;
        r.data_out = 8'hFF;
        if (m == sfmc_pkg::MODE_XCHG) begin
            r.data_out = card_exchange(b);
        end else if (m == sfmc_pkg::MODE_SEL) begin
            byte_pos = 16'd0;
        end else if (m == sfmc_pkg::MODE_REL) begin
            card_release();
        end else if (countdown != 16'd0) begin
            countdown--;
            if (countdown == 16'd0) begin
                status_reg = (status_reg | sfmc_pkg::ST_READY) & ~sfmc_pkg::ST_BUSY;
                irq_pend = 1'b1;
            end
        end
        r.status_out    = status_reg;
        r.interrupt_out = irq_en & irq_pend;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch in result %0d: %s got %0h expected %0h",
                 result_count, what, got, want);
        err_count++;
    endtask

    // Results are checked at the rising edge at which they are taken.
    always @(posedge clk) begin
        sfmc_pkg::t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result", int'(out_item), 0);
            end else begin
                want = expected_q.pop_front();
                if (out_item.data_out !== want.data_out)
                    report_mismatch("data_out", int'(out_item.data_out),
                                    int'(want.data_out));
                if (out_item.status_out !== want.status_out)
                    report_mismatch("status_out", int'(out_item.status_out),
                                    int'(want.status_out));
                if (out_item.interrupt_out !== want.interrupt_out)
                    report_mismatch("interrupt_out", int'(out_item.interrupt_out),
                                    int'(want.interrupt_out));
            end
            result_count++;
        end
    end

    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic send_item(logic [1:0] m, logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{mode: m, data_in: b};
        do
            @(posedge clk);
        while (in_stall);
        expected_q.push_back(predict_card(m, b));
        item_count++;
        @(negedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (expected_q.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [15:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == sfmc_pkg::CFG_DEVICE_ID)
            id_reg = v;
        else
            delay_reg = v;
    endtask

    task automatic send_cmd(logic [7:0] c);
        send_item(sfmc_pkg::MODE_SEL, 8'h00);
        send_item(sfmc_pkg::MODE_XCHG, c);
    endtask

    task automatic send_addr(logic [7:0] a1, logic [7:0] a2, logic [7:0] a3, logic [7:0] a4);
        send_item(sfmc_pkg::MODE_XCHG, a1);
        send_item(sfmc_pkg::MODE_XCHG, a2);
        send_item(sfmc_pkg::MODE_XCHG, a3);
        send_item(sfmc_pkg::MODE_XCHG, a4);
    endtask

    task automatic test_directed();
        send_cmd(sfmc_pkg::CMD_IDENTIFY);
        repeat (6) send_item(sfmc_pkg::MODE_XCHG, 8'hA5);
        send_cmd(sfmc_pkg::CMD_READ_ID);
        repeat (3) send_item(sfmc_pkg::MODE_XCHG, 8'h00);
        send_cmd(sfmc_pkg::CMD_SET_IRQ);
        send_item(sfmc_pkg::MODE_XCHG, 8'h02);
        // Program at the very top of the card, with an address that aliases.
        send_cmd(sfmc_pkg::CMD_PAGE_PROGRAM);
        send_addr(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_item(sfmc_pkg::MODE_XCHG, 8'h00);
        send_item(sfmc_pkg::MODE_XCHG, 8'h5A);
        send_item(sfmc_pkg::MODE_REL, 8'hFF);
        repeat (3) send_item(sfmc_pkg::MODE_TICK, 8'h00);
        send_cmd(sfmc_pkg::CMD_READ_STATUS);
        send_item(sfmc_pkg::MODE_XCHG, 8'h00);
        send_cmd(sfmc_pkg::CMD_CLEAR_STATUS);
        send_item(sfmc_pkg::MODE_XCHG, 8'h00);
        send_item(sfmc_pkg::MODE_REL, 8'h00);
    endtask

    task automatic test_read_back();
        send_cmd(sfmc_pkg::CMD_READ_ARRAY);
        send_addr(8'h03, 8'hFF, 8'h03, 8'h7F);
        repeat (6) send_item(sfmc_pkg::MODE_XCHG, 8'h00);
        send_cmd(sfmc_pkg::CMD_SECTOR_ERASE);
        send_item(sfmc_pkg::MODE_XCHG, 8'hFF);
        send_item(sfmc_pkg::MODE_XCHG, 8'hFF);
        send_item(sfmc_pkg::MODE_REL, 8'h00);
        // Release without a new select repeats the erase and reloads the countdown.
        send_item(sfmc_pkg::MODE_REL, 8'h00);
        repeat (4) send_item(sfmc_pkg::MODE_TICK, 8'h00);
        send_cmd(sfmc_pkg::CMD_CHIP_ERASE);
        send_addr(8'h00, 8'h00, 8'h00, 8'h00);
        send_item(sfmc_pkg::MODE_REL, 8'h00);
        send_cmd(8'h3C);
        send_item(sfmc_pkg::MODE_XCHG, 8'hC3);
    endtask

    task automatic random_txn();
        int kind;
        int n;
        logic [7:0] c;
        kind = $urandom_range(99);
        if (kind < 8) begin
            // Stray items outside any framed command.
            n = $urandom_range(4, 1);
            repeat (n) send_item(2'($urandom_range(3)), 8'($urandom));
            return;
        end
        if (kind < 25)
            c = sfmc_pkg::CMD_READ_ARRAY;
        else if (kind < 45)
            c = sfmc_pkg::CMD_PAGE_PROGRAM;
        else if (kind < 52)
            c = sfmc_pkg::CMD_READ_STATUS;
        else if (kind < 58)
            c = sfmc_pkg::CMD_READ_ID;
        else if (kind < 63)
            c = sfmc_pkg::CMD_IDENTIFY;
        else if (kind < 70)
            c = sfmc_pkg::CMD_SET_IRQ;
        else if (kind < 77)
            c = sfmc_pkg::CMD_CLEAR_STATUS;
        else if (kind < 80)
            c = sfmc_pkg::CMD_SECTOR_ERASE;
        else begin
            c = 8'($urandom);
            if (c == sfmc_pkg::CMD_CHIP_ERASE)
                c = sfmc_pkg::CMD_IDENTIFY;
        end
        send_cmd(c);
        // A narrow address range makes reads land on freshly programmed pages.
        if (c == sfmc_pkg::CMD_READ_ARRAY || c == sfmc_pkg::CMD_PAGE_PROGRAM) begin
            if ($urandom_range(3) == 0)
                send_addr(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            else
                send_addr(8'h00, 8'($urandom_range(1)), 8'($urandom_range(3)),
                          8'($urandom_range(7)));
        end
        n = (c == sfmc_pkg::CMD_SECTOR_ERASE) ? 2 : $urandom_range(12);
        repeat (n) send_item(sfmc_pkg::MODE_XCHG, 8'($urandom));
        if ($urandom_range(4) != 0)
            send_item(sfmc_pkg::MODE_REL, 8'($urandom));
        n = $urandom_range(5);
        repeat (n) send_item(sfmc_pkg::MODE_TICK, 8'($urandom));
    endtask

    task automatic test_random_phase(int idle_pct, int stall_pct, int count);
        int stop_at;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        stop_at = item_count + count;
        while (item_count < stop_at)
            random_txn();
        settle();
    endtask

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = sfmc_pkg::CFG_DEVICE_ID;
        cfg_data = 16'd0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        err_count = 0;
        item_count = 0;
        result_count = 0;
        for (int i = 0; i < 128; i++)
            page_buf[i] = 8'h00;
        cur_cmd = sfmc_pkg::CMD_IDENTIFY;
        byte_pos = 16'd0;
        card_addr = 25'd0;
        status_reg = sfmc_pkg::ST_BUSY | sfmc_pkg::ST_UNLOCKED | sfmc_pkg::ST_READY;
        irq_en = 1'b0;
        irq_pend = 1'b0;
        countdown = 16'd0;
        id_reg = 16'hC221;
        delay_reg = 16'd5000;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        write_reg(sfmc_pkg::CFG_DONE_DELAY, 16'd1);
        test_directed();
        settle();
        write_reg(sfmc_pkg::CFG_DEVICE_ID, 16'hFFFF);
        write_reg(sfmc_pkg::CFG_DONE_DELAY, 16'd2);
        test_read_back();
        settle();
        write_reg(sfmc_pkg::CFG_DEVICE_ID, 16'h0000);
        write_reg(sfmc_pkg::CFG_DONE_DELAY, 16'd3);
        test_random_phase(0, 0, 80);
        write_reg(sfmc_pkg::CFG_DEVICE_ID, 16'($urandom));
        write_reg(sfmc_pkg::CFG_DONE_DELAY, 16'hFFFF);
        test_random_phase(61, 0, 80);
        write_reg(sfmc_pkg::CFG_DONE_DELAY, 16'd4);
        test_random_phase(0, 61, 80);
        write_reg(sfmc_pkg::CFG_DEVICE_ID, 16'h8001);
        write_reg(sfmc_pkg::CFG_DONE_DELAY, 16'd1);
        test_random_phase(31, 31, 80);

        $display("Covered %0d items and %0d results over all commands,", item_count,
                 result_count);
        $display("erases, programs and idling phases; %0d mismatches.", err_count);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Allows for the clearing pass, one chip erase and many sector erases.
    initial begin
        #60000000;
        $display("TB_ERROR");
        $finish;
    end
endmodule
